// ===== design/nozzle_clean_auto_drain_sequencer_assert.svh =====
// Assertion macros for the nozzle clean and auto drain sequencer.
`ifndef NOZZLE_CLEAN_AUTO_DRAIN_SEQUENCER_ASSERT_SVH
`define NOZZLE_CLEAN_AUTO_DRAIN_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define NCAD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define NCAD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ncad_pkg.sv =====
// Shared types and constants of the nozzle clean and auto drain sequencer.
package ncad_pkg;

    typedef enum logic [1:0] {
        OP_TICK_100MS = 2'd0,
        OP_TICK_1MIN  = 2'd1,
        OP_SET_CLEAN  = 2'd2,
        OP_STOP_CLEAN = 2'd3
    } op_t;

    localparam logic [1:0] VALVE_HOLD  = 2'd0;
    localparam logic [1:0] VALVE_OPEN  = 2'd1;
    localparam logic [1:0] VALVE_CLOSE = 2'd2;

    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_CLEAN = 2'd1;
    localparam logic [1:0] MOTOR_BIDET = 2'd2;

    localparam logic [2:0] NOZZLE_HOME = 3'd0;
    localparam logic [2:0] NOZZLE_FULL = 3'd5;

    localparam logic [3:0] MOTORS_ALL = 4'hF;

    localparam logic [2:0] STEP_EXTEND_CLEAN  = 3'd0;
    localparam logic [2:0] STEP_RINSE_CLEAN   = 3'd1;
    localparam logic [2:0] STEP_RETRACT_CLEAN = 3'd2;
    localparam logic [2:0] STEP_EXTEND_BIDET  = 3'd3;
    localparam logic [2:0] STEP_RINSE_BIDET   = 3'd4;
    localparam logic [2:0] STEP_RETRACT_BIDET = 3'd5;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_AUTO_DRAIN_EN  = 3'd0;
    localparam logic [2:0] REG_RINSE_ON       = 3'd1;
    localparam logic [2:0] REG_RINSE_OFF      = 3'd2;
    localparam logic [2:0] REG_RINSE_DRAIN    = 3'd3;
    localparam logic [2:0] REG_DRAIN_WAIT     = 3'd4;

    localparam logic [15:0] RST_RINSE_ON    = 16'd100;
    localparam logic [15:0] RST_RINSE_OFF   = 16'd1800;
    localparam logic [15:0] RST_RINSE_DRAIN = 16'd1200;
    localparam logic [15:0] RST_DRAIN_WAIT  = 16'd2879;

    typedef struct packed {
        logic        auto_drain_enable;
        logic [15:0] rinse_ticks_power_on;
        logic [15:0] rinse_ticks_power_off;
        logic [15:0] rinse_ticks_auto_drain;
        logic [15:0] drain_wait_minutes;
    } cfg_t;

    typedef struct packed {
        logic        clean_active;
        logic [15:0] clean_ticks;
        logic [2:0]  clean_step;
        logic        drain_active;
        logic [15:0] drain_minutes;
    } state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic       start_value;
        logic       power_on;
        logic [3:0] motors_done;
        logic       water_full;
        logic       mode_is_wait;
        logic       seat_occupied;
        logic       sterilize_all_active;
        logic       sterilize_after_active;
        logic       seat_clean_active;
        logic       overflow_error;
    } event_t;

    typedef struct packed {
        logic [1:0]  valve_cmd;
        logic [1:0]  motor_select;
        logic [2:0]  motor_target;
        logic        mode_to_wait;
        logic        clean_running;
        logic [2:0]  step_now;
        logic        drain_triggered;
        logic [15:0] minutes_idle;
    } result_t;

endpackage

// ===== design/nozzle_clean_auto_drain_sequencer.sv =====
// Top level of the nozzle clean and auto drain sequencer.
//
// Usage:
//   Events (100 ms tick, 1 min tick, clean request, stop request) enter on the
//   in_valid/in_ready channel together with the status bits of the appliance.
//   Every event gives exactly one result item on out_valid/out_ready with the
//   valve and motor commands and the sequencer state after the event.
//   An accepted item lands in the input register; once the result register is
//   free or being read, the step logic updates the state and loads the result
//   register. One item per cycle is taken sustained while out_ready stays high:
//   the state registers feed the step logic of the following item directly.
//   When the receiver stalls, the result register holds its item and the
//   input register holds one more; in_ready falls only when both are full.
//   Reset clears the valid bits, the clean and drain state, and loads the
//   configuration defaults (power-on rinse 100 ticks, power-off rinse 1800,
//   drain rinse 1200, drain wait 2879 minutes, auto drain off).
//   The user must write configuration over the APB port only while no item is
//   in flight (unenforced); an enable register write also clears idle minutes.
module nozzle_clean_auto_drain_sequencer
    import ncad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic              start_value,
    input  logic              power_on,
    input  logic [3:0]        motors_done,
    input  logic              water_full,
    input  logic              mode_is_wait,
    input  logic              seat_occupied,
    input  logic              sterilize_all_active,
    input  logic              sterilize_after_active,
    input  logic              seat_clean_active,
    input  logic              overflow_error,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        valve_cmd,
    output logic [1:0]        motor_select,
    output logic [2:0]        motor_target,
    output logic              mode_to_wait,
    output logic              clean_running,
    output logic [2:0]        step_now,
    output logic              drain_triggered,
    output logic [15:0]       minutes_idle
);

    cfg_t    cfg;
    logic    clear_minutes;

    logic    in_valid_reg;
    event_t  in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    state_t  state_reg;

    state_t  state_next;
    result_t res_next;
    logic    advance;

    ncad_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .cfg           (cfg),
        .clear_minutes (clear_minutes)
    );

    ncad_step u_step (
        .ev      (in_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Move the held event into the result register when that slot frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input stage: valid bit under reset, payload captured on accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg.opcode                 <= opcode;
            in_reg.start_value            <= start_value;
            in_reg.power_on               <= power_on;
            in_reg.motors_done            <= motors_done;
            in_reg.water_full             <= water_full;
            in_reg.mode_is_wait           <= mode_is_wait;
            in_reg.seat_occupied          <= seat_occupied;
            in_reg.sterilize_all_active   <= sterilize_all_active;
            in_reg.sterilize_after_active <= sterilize_after_active;
            in_reg.seat_clean_active      <= seat_clean_active;
            in_reg.overflow_error         <= overflow_error;
        end
    end

    // Sequencer state: advance with each event, clear minutes on enable write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (clear_minutes)
                state_reg.drain_minutes <= 16'd0;
        end
    end

    // Result stage: hold while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res_next;
    end

    assign out_valid       = out_valid_reg;
    assign valve_cmd       = out_reg.valve_cmd;
    assign motor_select    = out_reg.motor_select;
    assign motor_target    = out_reg.motor_target;
    assign mode_to_wait    = out_reg.mode_to_wait;
    assign clean_running   = out_reg.clean_running;
    assign step_now        = out_reg.step_now;
    assign drain_triggered = out_reg.drain_triggered;
    assign minutes_idle    = out_reg.minutes_idle;

`include "nozzle_clean_auto_drain_sequencer_assert.svh"

    `NCAD_ASSERT_NOW(a_step_in_range, 1'b1, state_reg.clean_step <= STEP_RETRACT_BIDET, "clean step out of range")
    `NCAD_ASSERT_NOW(a_stop_clears, out_valid_reg && out_reg.mode_to_wait, !out_reg.clean_running && out_reg.step_now == STEP_EXTEND_CLEAN && !out_reg.drain_triggered, "stop left clean state behind")
    `NCAD_ASSERT_NOW(a_no_move_home, out_valid_reg && out_reg.motor_select == MOTOR_NONE, out_reg.motor_target == NOZZLE_HOME, "motor target without motor")
    `NCAD_ASSERT_NEXT(a_stall_holds_both, in_valid_reg && out_valid_reg && !out_ready, in_valid_reg && out_valid_reg, "stall lost a held item")

endmodule

// ===== design/ncad_apb_regs.sv =====
// APB configuration registers of the nozzle clean and auto drain sequencer.
module ncad_apb_regs
    import ncad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg,
    output logic              clear_minutes
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Any write to the enable register restarts the idle minute count.
    assign clear_minutes = wr_en && (reg_idx == REG_AUTO_DRAIN_EN);
    assign cfg           = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_drain_enable      <= 1'b0;
            cfg_reg.rinse_ticks_power_on   <= RST_RINSE_ON;
            cfg_reg.rinse_ticks_power_off  <= RST_RINSE_OFF;
            cfg_reg.rinse_ticks_auto_drain <= RST_RINSE_DRAIN;
            cfg_reg.drain_wait_minutes     <= RST_DRAIN_WAIT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_AUTO_DRAIN_EN: cfg_reg.auto_drain_enable      <= pwdata[0];
                REG_RINSE_ON:      cfg_reg.rinse_ticks_power_on   <= pwdata[15:0];
                REG_RINSE_OFF:     cfg_reg.rinse_ticks_power_off  <= pwdata[15:0];
                REG_RINSE_DRAIN:   cfg_reg.rinse_ticks_auto_drain <= pwdata[15:0];
                REG_DRAIN_WAIT:    cfg_reg.drain_wait_minutes     <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_AUTO_DRAIN_EN: prdata = {31'd0, cfg_reg.auto_drain_enable};
            REG_RINSE_ON:      prdata = {16'd0, cfg_reg.rinse_ticks_power_on};
            REG_RINSE_OFF:     prdata = {16'd0, cfg_reg.rinse_ticks_power_off};
            REG_RINSE_DRAIN:   prdata = {16'd0, cfg_reg.rinse_ticks_auto_drain};
            REG_DRAIN_WAIT:    prdata = {16'd0, cfg_reg.drain_wait_minutes};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== design/ncad_step.sv =====
// Next-state and result logic for one event of the sequencer.
module ncad_step
    import ncad_pkg::*;
(
    input  event_t  ev,
    input  state_t  st,
    input  cfg_t    cfg,
    output state_t  st_next,
    output result_t res
);

    state_t     nxt;
    logic [1:0] valve;
    logic [1:0] msel;
    logic [2:0] mtgt;
    logic       to_wait;
    logic       drain_ok;

    // Drop a running clean and the drain flag; no effect while idle.
    function automatic state_t stop_clean(input state_t s);
        state_t r;
        r = s;
        if (s.clean_active)
        begin
            r.clean_active  = 1'b0;
            r.clean_ticks   = 16'd0;
            r.clean_step    = STEP_EXTEND_CLEAN;
            r.drain_active  = 1'b0;
            r.drain_minutes = 16'd0;
        end
        return r;
    endfunction

    assign drain_ok = cfg.auto_drain_enable && ev.water_full && ev.power_on &&
                      ev.mode_is_wait && !ev.seat_occupied &&
                      !ev.sterilize_all_active && !ev.sterilize_after_active &&
                      !ev.seat_clean_active && !st.clean_active && !ev.overflow_error;

    always_comb
    begin
        nxt     = st;
        valve   = VALVE_HOLD;
        msel    = MOTOR_NONE;
        mtgt    = NOZZLE_HOME;
        to_wait = 1'b0;
        case (op_t'(ev.opcode))
            OP_TICK_100MS:
            begin
                if (st.clean_active && ev.motors_done == MOTORS_ALL)
                begin
                    if (ev.power_on)
                    begin
                        if (st.clean_ticks != 16'd0)
                        begin
                            nxt.clean_ticks = st.clean_ticks - 16'd1;
                            valve           = VALVE_OPEN;
                        end
                        else
                        begin
                            nxt     = stop_clean(st);
                            to_wait = 1'b1;
                        end
                    end
                    else
                    begin
                        case (st.clean_step)
                            STEP_EXTEND_CLEAN:
                            begin
                                msel           = MOTOR_CLEAN;
                                mtgt           = NOZZLE_FULL;
                                nxt.clean_step = STEP_RINSE_CLEAN;
                            end
                            STEP_RINSE_CLEAN, STEP_RINSE_BIDET:
                            begin
                                if (st.clean_ticks != 16'd0)
                                begin
                                    nxt.clean_ticks = st.clean_ticks - 16'd1;
                                    valve           = VALVE_OPEN;
                                end
                                else
                                begin
                                    nxt.clean_step = st.clean_step + 3'd1;
                                end
                            end
                            STEP_RETRACT_CLEAN:
                            begin
                                msel            = MOTOR_CLEAN;
                                mtgt            = NOZZLE_HOME;
                                valve           = VALVE_CLOSE;
                                nxt.clean_ticks = 16'd0;
                                nxt.clean_step  = STEP_EXTEND_BIDET;
                            end
                            STEP_EXTEND_BIDET:
                            begin
                                msel            = MOTOR_BIDET;
                                mtgt            = NOZZLE_FULL;
                                nxt.clean_ticks = cfg.rinse_ticks_power_off;
                                nxt.clean_step  = STEP_RINSE_BIDET;
                            end
                            STEP_RETRACT_BIDET:
                            begin
                                msel    = MOTOR_BIDET;
                                mtgt    = NOZZLE_HOME;
                                nxt     = stop_clean(st);
                                to_wait = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_TICK_1MIN:
            begin
                if (drain_ok)
                begin
                    if (st.drain_minutes < cfg.drain_wait_minutes)
                    begin
                        nxt.drain_minutes = st.drain_minutes + 16'd1;
                    end
                    else
                    begin
                        // Power is known on here, so load the drain rinse count.
                        nxt.drain_active = 1'b1;
                        nxt.clean_active = 1'b1;
                        nxt.clean_ticks  = cfg.rinse_ticks_auto_drain;
                    end
                end
                else
                begin
                    nxt.drain_minutes = 16'd0;
                end
            end
            OP_SET_CLEAN:
            begin
                nxt.clean_active = ev.start_value;
                if (ev.start_value)
                begin
                    if (!ev.power_on)
                        nxt.clean_ticks = cfg.rinse_ticks_power_off;
                    else if (st.drain_active)
                        nxt.clean_ticks = cfg.rinse_ticks_auto_drain;
                    else
                        nxt.clean_ticks = cfg.rinse_ticks_power_on;
                end
            end
            OP_STOP_CLEAN:
            begin
                nxt     = stop_clean(st);
                to_wait = st.clean_active;
            end
            default: ;
        endcase
    end

    assign st_next             = nxt;
    assign res.valve_cmd       = valve;
    assign res.motor_select    = msel;
    assign res.motor_target    = mtgt;
    assign res.mode_to_wait    = to_wait;
    assign res.clean_running   = nxt.clean_active;
    assign res.step_now        = nxt.clean_step;
    assign res.drain_triggered = nxt.drain_active;
    assign res.minutes_idle    = nxt.drain_minutes;

endmodule

// ===== bench/nozzle_clean_auto_drain_sequencer_test.sv =====
// Self-checking testbench for the nozzle clean and auto drain sequencer.
module nozzle_clean_auto_drain_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ncad_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 1650;
    localparam int LONG_HOLD = 120;

    // Block ports; every input starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] opcode = '0;
    logic start_value = 1'b0;
    logic power_on = 1'b0;
    logic [3:0] motors_done = '0;
    logic water_full = 1'b0;
    logic mode_is_wait = 1'b0;
    logic seat_occupied = 1'b0;
    logic sterilize_all_active = 1'b0;
    logic sterilize_after_active = 1'b0;
    logic seat_clean_active = 1'b0;
    logic overflow_error = 1'b0;

    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] valve_cmd;
    logic [1:0] motor_select;
    logic [2:0] motor_target;
    logic mode_to_wait;
    logic clean_running;
    logic [2:0] step_now;
    logic drain_triggered;
    logic [15:0] minutes_idle;

    // Predicted sequencer state and register copy.
    state_t nozzle;
    cfg_t regs;

    // Events waiting for the driver, and commands predicted for accepted events.
    event_t pending_events[$];
    result_t predicted_results[$];

    // Driver state: the event on the ports and the burst/gap pacing.
    event_t offered_event = '0;
    logic event_offered = 1'b0;
    int burst_left = 0;
    int gap_left = 0;
    int gap_max = 4;

    // Receiver pacing; the stimulus raises hold_requests to ask for a long hold.
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int pace_mode = 0;
    int pace_count = 0;

    int cycles = 0;
    int mismatches = 0;
    int results_checked = 0;
    int items_queued = 0;
    int settings_used = 0;
    int register_writes = 0;
    int sequences_finished = 0;
    int drain_starts = 0;

    nozzle_clean_auto_drain_sequencer dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stop a running clean and clear all clean and drain state.
    // Return whether anything was actually stopped.
    function automatic logic halt_clean();
        if (!nozzle.clean_active)
            return 1'b0;
        nozzle = '0;
        return 1'b1;
    endfunction

    // Set or clear the clean request; a start loads the rinse count that
    // fits the power state and whether auto drain started it.
    function automatic void load_clean(input logic start, input logic power);
        nozzle.clean_active = start;
        if (start)
        begin
            if (!power)
                nozzle.clean_ticks = regs.rinse_ticks_power_off;
            else if (nozzle.drain_active)
                nozzle.clean_ticks = regs.rinse_ticks_auto_drain;
            else
                nozzle.clean_ticks = regs.rinse_ticks_power_on;
        end
    endfunction

    // Apply one event to the predicted state and return the commands it gives.
    function automatic result_t advance_sequencer(input event_t ev);
        result_t r;
        logic drain_ok;
        r = '0;
        case (ev.opcode)
            OP_TICK_100MS:
            begin
                // Ticks only count while a clean runs and every motor is at rest.
                if (nozzle.clean_active && ev.motors_done == MOTORS_ALL)
                begin
                    if (ev.power_on)
                    begin
                        if (nozzle.clean_ticks != 0)
                        begin
                            nozzle.clean_ticks = nozzle.clean_ticks - 16'd1;
                            r.valve_cmd = VALVE_OPEN;
                        end
                        else
                            r.mode_to_wait = halt_clean();
                    end
                    else
                    begin
                        case (nozzle.clean_step)
                            STEP_EXTEND_CLEAN:
                            begin
                                r.motor_select = MOTOR_CLEAN;
                                r.motor_target = NOZZLE_FULL;
                                nozzle.clean_step = nozzle.clean_step + 3'd1;
                            end
                            STEP_RINSE_CLEAN, STEP_RINSE_BIDET:
                            begin
                                if (nozzle.clean_ticks != 0)
                                begin
                                    nozzle.clean_ticks = nozzle.clean_ticks - 16'd1;
                                    r.valve_cmd = VALVE_OPEN;
                                end
                                else
                                    nozzle.clean_step = nozzle.clean_step + 3'd1;
                            end
                            STEP_RETRACT_CLEAN:
                            begin
                                r.motor_select = MOTOR_CLEAN;
                                r.motor_target = NOZZLE_HOME;
                                r.valve_cmd = VALVE_CLOSE;
                                nozzle.clean_ticks = '0;
                                nozzle.clean_step = nozzle.clean_step + 3'd1;
                            end
                            STEP_EXTEND_BIDET:
                            begin
                                r.motor_select = MOTOR_BIDET;
                                r.motor_target = NOZZLE_FULL;
                                nozzle.clean_ticks = regs.rinse_ticks_power_off;
                                nozzle.clean_step = nozzle.clean_step + 3'd1;
                            end
                            STEP_RETRACT_BIDET:
                            begin
                                r.motor_select = MOTOR_BIDET;
                                r.motor_target = NOZZLE_HOME;
                                r.mode_to_wait = halt_clean();
                                sequences_finished++;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            OP_TICK_1MIN:
            begin
                // Count idle minutes only while every drain condition holds;
                // any break restarts the count.
                drain_ok = regs.auto_drain_enable && ev.water_full && ev.power_on &&
                           ev.mode_is_wait && !ev.seat_occupied &&
                           !ev.sterilize_all_active && !ev.sterilize_after_active &&
                           !ev.seat_clean_active && !nozzle.clean_active &&
                           !ev.overflow_error;
                if (drain_ok)
                begin
                    if (nozzle.drain_minutes < regs.drain_wait_minutes)
                        nozzle.drain_minutes = nozzle.drain_minutes + 16'd1;
                    else
                    begin
                        nozzle.drain_active = 1'b1;
                        load_clean(1'b1, ev.power_on);
                        drain_starts++;
                    end
                end
                else
                    nozzle.drain_minutes = '0;
            end
            OP_SET_CLEAN:
                load_clean(ev.start_value, ev.power_on);
            OP_STOP_CLEAN:
                r.mode_to_wait = halt_clean();
            default: ;
        endcase
        r.clean_running = nozzle.clean_active;
        r.step_now = nozzle.clean_step;
        r.drain_triggered = nozzle.drain_active;
        r.minutes_idle = nozzle.drain_minutes;
        return r;
    endfunction

    // Build an event; flip toggles drain conditions away from the all-good set
    // (water full, wait mode, no user, no sterilize, no seat clean, no overflow).
    function automatic event_t compose_event(input op_t op, input logic start,
                                             input logic power, input logic [3:0] motors,
                                             input logic [6:0] flip);
        event_t e;
        e.opcode = op;
        e.start_value = start;
        e.power_on = power;
        e.motors_done = motors;
        {e.water_full, e.mode_is_wait, e.seat_occupied, e.sterilize_all_active,
         e.sterilize_after_active, e.seat_clean_active, e.overflow_error} = 7'b1100000 ^ flip;
        return e;
    endfunction

    // Draw a mostly well-formed event: frequent ticks with motors at rest, minute
    // ticks that mostly meet the drain conditions, occasional requests and stops,
    // and some fully random noise.
    function automatic event_t next_event(input logic power, input int stop_pct);
        int roll;
        logic [6:0] flip;
        logic [3:0] motors;
        logic start;
        roll = $urandom_range(0, 99);
        flip = ($urandom_range(0, 4) == 0) ? 7'(1 << $urandom_range(0, 6)) : '0;
        motors = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(0, 14)) : MOTORS_ALL;
        start = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0)
            power = !power;
        if (roll < stop_pct)
            return compose_event(OP_STOP_CLEAN, start, power, motors, flip);
        if (roll < 14)
            return compose_event(OP_SET_CLEAN, $urandom_range(0, 4) != 0, power, motors, flip);
        if (roll < 30)
            return compose_event(OP_TICK_1MIN, start, $urandom_range(0, 7) != 0, motors, flip);
        if (roll < 90)
            return compose_event(OP_TICK_100MS, start, power, motors, flip);
        return event_t'(15'($urandom()));
    endfunction

    // Rinse counts: mostly short so sequences finish, now and then the extremes.
    function automatic logic [15:0] pick_ticks();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0)
            return 16'hFFFF;
        if (roll == 1)
            return 16'($urandom_range(0, 65535));
        return 16'($urandom_range(0, 5));
    endfunction

    task automatic offer_event(input event_t e);
        pending_events.push_back(e);
        items_queued++;
    endtask

    // Hold until the driver has nothing left and every predicted command is in.
    task automatic wait_idle();
        while (pending_events.size() != 0 || event_offered || predicted_results.size() != 0)
            @(posedge clk);
    endtask

    // Setup then access phase; the register takes the value at the access edge.
    task automatic apb_write(input logic [2:0] index, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({index, 2'b00});
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        register_writes++;
        case (index)
            REG_AUTO_DRAIN_EN:
            begin
                regs.auto_drain_enable = value[0];
                nozzle.drain_minutes = '0;
            end
            REG_RINSE_ON:    regs.rinse_ticks_power_on = value;
            REG_RINSE_OFF:   regs.rinse_ticks_power_off = value;
            REG_RINSE_DRAIN: regs.rinse_ticks_auto_drain = value;
            REG_DRAIN_WAIT:  regs.drain_wait_minutes = value;
            default: ;
        endcase
    endtask

    task automatic program_registers(input logic enable, input logic [15:0] rinse_on,
                                     input logic [15:0] rinse_off,
                                     input logic [15:0] rinse_drain,
                                     input logic [15:0] drain_wait);
        apb_write(REG_AUTO_DRAIN_EN, 16'(enable));
        apb_write(REG_RINSE_ON, rinse_on);
        apb_write(REG_RINSE_OFF, rinse_off);
        apb_write(REG_RINSE_DRAIN, rinse_drain);
        apb_write(REG_DRAIN_WAIT, drain_wait);
        settings_used++;
    endtask

    // Driver: predict each event as it is accepted, then offer the next one
    // from the queue in bursts separated by random gaps.
    always @(posedge clk)
    begin : drive_events
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted_results.push_back(advance_sequencer(offered_event));
                event_offered = 1'b0;
            end
            if (!event_offered)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_events.size() != 0)
                begin
                    offered_event = pending_events.pop_front();
                    event_offered = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = $urandom_range(0, gap_max);
                    end
                end
            end
            in_valid <= event_offered;
            {opcode, start_value, power_on, motors_done, water_full, mode_is_wait,
             seat_occupied, sterilize_all_active, sterilize_after_active,
             seat_clean_active, overflow_error} <= offered_event;
        end
    end

    // Receiver: a long hold on request, otherwise one of several stall patterns
    // that changes at random.
    always @(posedge clk)
    begin : pace_results
        logic ready_next;
        pace_count++;
        if (hold_left == 0 && hold_served < hold_requests)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ready_next = 1'b0;
        end
        else
        begin
            case (pace_mode)
                0: ready_next = 1'b1;
                1: ready_next = $urandom_range(0, 1);
                2: ready_next = ($urandom_range(0, 3) == 0);
                default: ready_next = (pace_count % 5) != 0;
            endcase
        end
        if ($urandom_range(0, 63) == 0)
            pace_mode = $urandom_range(0, 3);
        out_ready <= ready_next;
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: result %0d %s expected %0d, got %0d",
                     $time, results_checked, name, want, got);
            mismatches++;
        end
    endfunction

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {valve_cmd, motor_select, motor_target, mode_to_wait, clean_running,
                   step_now, drain_triggered, minutes_idle};
            if (predicted_results.size() == 0)
            begin
                $display("%0t ns: result with no event pending, expected none, got %h",
                         $time, got);
                mismatches++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("valve_cmd", 16'(want.valve_cmd), 16'(got.valve_cmd));
                check_field("motor_select", 16'(want.motor_select), 16'(got.motor_select));
                check_field("motor_target", 16'(want.motor_target), 16'(got.motor_target));
                check_field("mode_to_wait", 16'(want.mode_to_wait), 16'(got.mode_to_wait));
                check_field("clean_running", 16'(want.clean_running),
                            16'(got.clean_running));
                check_field("step_now", 16'(want.step_now), 16'(got.step_now));
                check_field("drain_triggered", 16'(want.drain_triggered),
                            16'(got.drain_triggered));
                check_field("minutes_idle", want.minutes_idle, got.minutes_idle);
            end
            results_checked++;
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still pending",
                     cycles, predicted_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_no;
        int stop_pct;
        logic phase_power;

        nozzle = '0;
        regs = '{1'b0, RST_RINSE_ON, RST_RINSE_OFF, RST_RINSE_DRAIN, RST_DRAIN_WAIT};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset defaults: idle stop and tick, clear,
        // start, motors busy, rinse, restart while running, power-off steps.
        offer_event(compose_event(OP_STOP_CLEAN, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b1, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b1, 4'b0111, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b1, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b1, 1'b0, MOTORS_ALL, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b0, MOTORS_ALL, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b0, MOTORS_ALL, '0));
        offer_event(compose_event(OP_STOP_CLEAN, 1'b0, 1'b0, MOTORS_ALL, '0));
        offer_event(event_t'('1));
        offer_event(event_t'('0));
        wait_idle();

        // Power-on/off rinse 0, drain rinse 2, no drain wait: the drain fires on
        // the first good minute, then a full power-off pass walks all six steps.
        program_registers(1'b1, 16'd0, 16'd0, 16'd2, 16'd0);
        offer_event(compose_event(OP_TICK_1MIN, 1'b0, 1'b1, MOTORS_ALL, '0));
        repeat (3) offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b1, 1'b0, MOTORS_ALL, '0));
        repeat (6) offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b0, MOTORS_ALL, '0));
        offer_event(compose_event(OP_SET_CLEAN, 1'b1, 1'b1, MOTORS_ALL, '0));
        offer_event(compose_event(OP_TICK_100MS, 1'b0, 1'b1, MOTORS_ALL, '0));

        // Random phases, each under its own register setting; the first two
        // take the top and bottom of every register.
        phase_no = 0;
        while (items_queued < ITEM_TARGET)
        begin
            phase_no++;
            wait_idle();
            if (phase_no == 1)
                program_registers(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (phase_no == 2)
                program_registers(1'b0, 16'd0, 16'd0, 16'd0, 16'd0);
            else
                program_registers($urandom_range(0, 9) < 7, pick_ticks(), pick_ticks(),
                                  pick_ticks(),
                                  ($urandom_range(0, 9) == 0) ? 16'hFFFF :
                                  16'($urandom_range(0, 4)));
            phase_power = $urandom_range(0, 1);
            stop_pct = $urandom_range(1, 6);
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
            repeat ($urandom_range(60, 140))
                offer_event(next_event(phase_power, stop_pct));
            // Now and then hold the results back while the sender keeps
            // pushing, so the block fills and drops in_ready.
            if (phase_no % 6 == 3)
            begin
                hold_requests++;
                gap_max = 0;
                repeat (40) offer_event(next_event(phase_power, stop_pct));
            end
        end

        wait_idle();
        repeat (10) @(posedge clk);
        $display("Checked %0d results from %0d events under %0d register settings (%0d writes).",
                 results_checked, items_queued, settings_used, register_writes);
        $display("Power-off sequences run to the end: %0d; auto-drain starts: %0d.",
                 sequences_finished, drain_starts);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
